// ===== rtl/core/sobel_edge_magnitude_defines.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SEM_ASSERT_SAME(label, clk, rst, ante, cons)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/sem_pkg.sv =====
// Types and constants of the Sobel edge magnitude block.
package sem_pkg;

   // Longest line the line store holds.
   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 16;
   localparam int FW_W      = 13;
   localparam int PIX_W     = 8;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = FW_W'(640);
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = ROW_W'(480);
   localparam logic [FW_W-1:0]  MIN_DIM            = FW_W'(3);
   localparam logic [FW_W-1:0]  MAX_DIM            = FW_W'(MAX_WIDTH);

   // Top bit of the square root of a 16-bit sum; it moves down two places per step.
   localparam logic [16:0] ROOT_FIRST_BIT = 17'h04000;

   // Register indexes, taken from the word address bit of the configuration port.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_ROOT
   } sem_state_type;

   typedef struct packed {
      logic accept;
      logic load_win;
      logic load_sq;
      logic root_step;
      logic load_rsp;
   } sem_ctrl_type;

endpackage

// ===== rtl/core/sobel_edge_magnitude.sv =====
// Streaming 3x3 Sobel edge magnitude with line store and APB configuration.
//
// The block takes 8-bit grey pixels in raster order, one word per handshake on the
// req_ channel, and returns for every pixel at column x >= 1 and row y >= 1 the
// clamped gradient magnitude of centre (x-1, y-1) on the rsp_ channel, together
// with that centre's column and row and a flag on the word caused by the last
// pixel of the frame. Centres on the left column or top row give zero; the right
// column and bottom row are never returned. A pixel that yields a result occupies
// the block through each step in turn: acceptance, the line store read-modify-write
// and window shift, the gradient squares, the square root, which takes one restoring
// step per cycle, and the output register load, which stretches for as long as an
// earlier word still waits there. A pixel that yields none (the first of each row
// and all of row 0) occupies it only for acceptance and the read-modify-write and
// window shift. The occupancy is set by the serial square root and by the single
// line store memory, whose registered read precedes the write-back of the shifted
// column. A finished word waits in the output register while the next pixel is
// taken in. The input is held off during reset. The line store is
// not cleared after reset: its contents before the first full rows of a frame
// only reach results that are forced to zero. frame_width is used saturated to
// 3..4096 and frame_height with a floor of 3; both should be written only while
// the block is idle.
module sobel_edge_magnitude
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Pixel input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel,
   // Result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_edge_magnitude,
   output logic [11:0]        rsp_out_col,
   output logic [15:0]        rsp_out_row,
   output logic               rsp_frame_last,
   // Configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

`include "sobel_edge_magnitude_defines.svh"

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [FW_W-1:0]  frame_width_ff;
   logic [ROW_W-1:0] frame_height_ff;
   logic             cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[ROW_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_FRAME_WIDTH:  prdata = {{(PDATA_W-FW_W){1'b0}}, frame_width_ff};
         REG_FRAME_HEIGHT: prdata = {{(PDATA_W-ROW_W){1'b0}}, frame_height_ff};
      endcase
   end

   // Width in use, saturated to the range the line store supports, and the
   // height with its floor of three rows.
   logic [FW_W-1:0]  width_eff;
   logic [ROW_W-1:0] height_eff;

   always_comb begin
      priority if (frame_width_ff < MIN_DIM) begin
         width_eff = MIN_DIM;
      end else if (frame_width_ff > MAX_DIM) begin
         width_eff = MAX_DIM;
      end else begin
         width_eff = frame_width_ff;
      end
   end

   assign height_eff = (frame_height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM)
                                                            : frame_height_ff;

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   sem_state_type state_ff, state_in;
   sem_ctrl_type  ctrl;
   logic          emit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [16:0]   root_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.accept = req_valid && !reset;
            if (ctrl.accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.load_win = 1'b1;
            state_in      = emit_ff ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            ctrl.load_sq = 1'b1;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            // One root step per cycle until the root bit has shifted out; then the
            // output register must be free, or be emptied in this cycle.
            if (root_bit_ff != '0) begin
               ctrl.root_step = 1'b1;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.load_rsp = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = reset || (state_ff != ST_IDLE);

   // ---------------------------------------------------------------------------
   // Position counters and the per-pixel item registers
   // ---------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             eol, eof;
   logic             emit_in, border_in;

   logic [PIX_W-1:0] pix_ff;
   logic [COL_W-1:0] item_col_ff;
   logic [ROW_W-1:0] item_row_ff;
   logic             border_ff;
   logic             last_ff;

   assign eol       = {1'b0, col_ff} >= (width_eff - FW_W'(1));
   assign eof       = eol && (row_ff >= height_eff - ROW_W'(1));
   assign emit_in   = (col_ff != '0) && (row_ff != '0);
   assign border_in = (col_ff == COL_W'(1)) || (row_ff == ROW_W'(1));

   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (eol) begin
         col_in = '0;
         row_in = eof ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         emit_ff <= 1'b0;
      end else if (ctrl.accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         pix_ff      <= req_pixel;
         item_col_ff <= col_ff - COL_W'(1);
         item_row_ff <= row_ff - ROW_W'(1);
         border_ff   <= border_in;
         last_ff     <= eof;
      end
   end

   // ---------------------------------------------------------------------------
   // Line store: one entry per column holds the older row in the upper byte and
   // the newer row in the lower byte. Read on accept, written back in the
   // following cycle, so an entry is never read before its write has landed.
   // ---------------------------------------------------------------------------
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic [COL_W-1:0]   wr_addr_ff;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         rd_data_ff <= line_mem[col_ff];
         wr_addr_ff <= col_ff;
      end
      if (ctrl.load_win) begin
         line_mem[wr_addr_ff] <= {rd_data_ff[PIX_W-1:0], pix_ff};
      end
   end

   // ---------------------------------------------------------------------------
   // 3x3 window, row-major with the newest column on the right
   // ---------------------------------------------------------------------------
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = rd_data_ff[2*PIX_W-1:PIX_W];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = rd_data_ff[PIX_W-1:0];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ctrl.load_win) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Gradients and their squares
   // ---------------------------------------------------------------------------
   logic signed [10:0] gx, gy;
   logic signed [21:0] gx_sq, gy_sq;
   logic [19:0]        sq_x_ff, sq_y_ff;

   assign gx = (11'(win_ff[2]) + {2'b0, win_ff[5], 1'b0} + 11'(win_ff[8]))
             - (11'(win_ff[0]) + {2'b0, win_ff[3], 1'b0} + 11'(win_ff[6]));
   assign gy = (11'(win_ff[6]) + {2'b0, win_ff[7], 1'b0} + 11'(win_ff[8]))
             - (11'(win_ff[0]) + {2'b0, win_ff[1], 1'b0} + 11'(win_ff[2]));
   assign gx_sq = gx * gx;
   assign gy_sq = gy * gy;

   always_ff @(posedge clock) begin
      if (ctrl.load_sq) begin
         sq_x_ff <= gx_sq[19:0];
         sq_y_ff <= gy_sq[19:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Square root, one restoring step per cycle. The first step starts from the sum
   // of squares, the later ones from the held remainder.
   // ---------------------------------------------------------------------------
   logic [20:0] sum_sq;
   logic [16:0] root_bit_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [16:0] rem_src;
   logic [16:0] trial;

   assign sum_sq      = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign rem_src     = (root_bit_ff == ROOT_FIRST_BIT) ? {1'b0, sum_sq[15:0]} : rem_ff;
   assign trial       = root_ff + root_bit_ff;
   assign root_bit_in = root_bit_ff >> 2;

   always_comb begin
      if (rem_src >= trial) begin
         rem_in  = rem_src - trial;
         root_in = (root_ff >> 1) + root_bit_ff;
      end else begin
         rem_in  = rem_src;
         root_in = root_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_bit_ff <= '0;
      end else if (ctrl.load_sq) begin
         root_bit_ff <= ROOT_FIRST_BIT;
      end else if (ctrl.root_step) begin
         root_bit_ff <= root_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sq) begin
         root_ff <= '0;
      end else if (ctrl.root_step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Clamp and output register
   // ---------------------------------------------------------------------------
   logic [7:0]  mag;
   logic [7:0]  mag_ff;
   logic [11:0] out_col_ff;
   logic [15:0] out_row_ff;
   logic        frame_last_ff;

   always_comb begin
      priority if (border_ff) begin
         mag = '0;
      end else if (sum_sq[20:16] != '0) begin
         mag = 8'hff;
      end else begin
         mag = root_ff[7:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         mag_ff        <= mag;
         out_col_ff    <= 12'(item_col_ff);
         out_row_ff    <= item_row_ff;
         frame_last_ff <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_magnitude = mag_ff;
   assign rsp_out_col        = out_col_ff;
   assign rsp_out_row        = out_row_ff;
   assign rsp_frame_last     = frame_last_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `SEM_ASSERT_NEXT(a_accept_starts_load, clock, reset, ctrl.accept, state_ff == ST_LOAD)
   `SEM_ASSERT_NEXT(a_frame_end_wraps, clock, reset, ctrl.accept && eof, col_ff == '0 && row_ff == '0)
   `SEM_ASSERT_NEXT(a_root_fills_output, clock, reset, ctrl.load_rsp, rsp_valid_ff && state_ff == ST_IDLE)
   `SEM_ASSERT_SAME(a_no_overwrite, clock, reset, ctrl.load_rsp, !rsp_valid_ff || !rsp_stall)

endmodule
